[rtl/mms_pkg.sv]
// Shared types and constants of the marginal scaling block.
// Depends on nothing; every other file imports it.
package mms_pkg;

	localparam int DEF_MAX_COLS  = 16;
	localparam int DEF_MAX_ROWS  = 16;
	localparam int DEF_FRAC_BITS = 24;

	localparam logic [4:0]  RST_NUM_COLS   = 5'd16;
	localparam logic [4:0]  RST_NUM_ROWS   = 5'd16;
	localparam logic [31:0] RST_TOLERANCE  = 32'd1678;
	localparam logic [15:0] RST_STEP_LIMIT = 16'd100;

	typedef enum logic [1:0] {
		REG_NUM_COLS   = 2'd0,
		REG_NUM_ROWS   = 2'd1,
		REG_TOLERANCE  = 2'd2,
		REG_STEP_LIMIT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_WR_ENTRY = 3'd0,
		MODE_WR_CTGT  = 3'd1,
		MODE_WR_RTGT  = 3'd2,
		MODE_RUN      = 3'd3,
		MODE_RD_ENTRY = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STAT_CONV  = 2'd0,
		STAT_LIMIT = 2'd1,
		STAT_ZERO  = 2'd2,
		STAT_READ  = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_WAIT, ST_PASS, ST_SUM_RD, ST_SUM_ACC, ST_SUM_END,
		ST_SCL_LD, ST_SCL_GAP, ST_DIV, ST_SCL_RD, ST_SCL_MUL, ST_SCL_WR,
		ST_PH_END, ST_REPLY
	} state_t;

	typedef struct packed {
		logic host_wr_entry;
		logic host_wr_ctgt;
		logic host_wr_rtgt;
		logic host_rd;
		logic sum_acc;
		logic acc_first;
		logic sum_store;
		logic step_clr;
		logic gap_upd;
		logic div_start;
		logic mul;
		logic scl_wr;
		logic res_read;
		logic res_run;
		logic row_phase;
	} cmd_t;

	typedef struct packed {
		logic acc_zero;
		logic div_busy;
		logic step_below;
	} sts_t;

endpackage

[rtl/mms_div.sv]
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on mms_pkg.
module mms_div import mms_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int SUM_W     = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             div_start,
	input  logic [31:0]      num,
	input  logic [SUM_W-1:0] den,
	output logic             div_busy,
	output logic [31:0]      factor
);
	localparam int NUM_W = 32 + FRAC_BITS;
	localparam int CNW   = $clog2(NUM_W + 1);

	logic [SUM_W-1:0] rem_q, den_q;
	logic [NUM_W-1:0] num_q, quo_q;
	logic [CNW-1:0]   cnt_q;
	logic             busy_q;
	logic [SUM_W:0]   trial, diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (div_start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			rem_q <= '0;
			den_q <= den;
			num_q <= {num, FRAC_BITS'(0)};
		end else if (busy_q) begin
			rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign div_busy = busy_q;
	// saturate when the quotient does not fit a word
	assign factor   = (|quo_q[NUM_W-1:32]) ? 32'hFFFF_FFFF : quo_q[31:0];
endmodule

[rtl/mms_dp.sv]
// Datapath: joint memory, targets, sums, accumulator, gap tracker, divider, multiplier.
// Depends on mms_pkg and mms_div.
module mms_dp import mms_pkg::*; #(
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int CIW       = 4,
	parameter int RIW       = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cmd_t           cmd,
	input  logic [RIW-1:0] r_idx,
	input  logic [CIW-1:0] c_idx,
	input  logic [3:0]     row,
	input  logic [3:0]     col,
	input  logic [31:0]    value,
	input  logic [31:0]    tolerance,
	output sts_t           sts,
	output logic [31:0]    read_value
);
	localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int SUM_W   = 32 + $clog2(MAX_DIM);
	localparam int DIW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH   = MAX_ROWS * MAX_COLS;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [31:0]      mem [DEPTH];
	logic [31:0]      col_tgt [MAX_COLS];
	logic [31:0]      row_tgt [MAX_ROWS];
	logic [SUM_W-1:0] sums [MAX_DIM];

	logic [31:0]      rd_q, tgt_q, rv_q;
	logic [SUM_W-1:0] sum_rd_q, acc_q, step_q, gap;
	logic [63:0]      prod_s1;
	logic             host_ok, rd_ok_q;
	logic [AW-1:0]    host_addr, ctrl_addr, wa, ra;
	logic [31:0]      wd, scaled, factor;
	logic [DIW-1:0]   d_idx;

	assign host_ok   = (32'(row) < 32'(MAX_ROWS)) && (32'(col) < 32'(MAX_COLS));
	assign host_addr = AW'(32'(row) * 32'(MAX_COLS) + 32'(col));
	assign ctrl_addr = AW'(32'(r_idx) * 32'(MAX_COLS) + 32'(c_idx));
	assign d_idx     = cmd.row_phase ? DIW'(r_idx) : DIW'(c_idx);

	assign scaled = (|prod_s1[63:32+FRAC_BITS]) ? 32'hFFFF_FFFF
	                                            : prod_s1[31+FRAC_BITS:FRAC_BITS];
	assign wa = cmd.host_wr_entry ? host_addr : ctrl_addr;
	assign wd = cmd.host_wr_entry ? value : scaled;
	assign ra = cmd.host_rd ? host_addr : ctrl_addr;

	always_ff @(posedge clk) begin
		if ((cmd.host_wr_entry && host_ok) || cmd.scl_wr) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.host_wr_ctgt && (32'(col) < 32'(MAX_COLS))) begin
			col_tgt[CIW'(col)] <= value;
		end
		if (cmd.host_wr_rtgt && (32'(row) < 32'(MAX_ROWS))) begin
			row_tgt[RIW'(row)] <= value;
		end
		tgt_q <= cmd.row_phase ? row_tgt[r_idx] : col_tgt[c_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_store) begin
			sums[d_idx] <= acc_q;
		end
		sum_rd_q <= sums[d_idx];
	end

	assign gap = (sum_rd_q >= SUM_W'(tgt_q)) ? sum_rd_q - SUM_W'(tgt_q)
	                                         : SUM_W'(tgt_q) - sum_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.sum_acc) begin
			acc_q <= (cmd.acc_first ? '0 : acc_q) + SUM_W'(rd_q);
		end
		if (cmd.step_clr) begin
			step_q <= '0;
		end else if (cmd.gap_upd && (gap > step_q)) begin
			step_q <= gap;
		end
		if (cmd.mul) begin
			prod_s1 <= 64'(rd_q) * 64'(factor);
		end
		if (cmd.host_rd) begin
			rd_ok_q <= host_ok;
		end
		if (cmd.res_read) begin
			rv_q <= rd_ok_q ? rd_q : 32'd0;
		end else if (cmd.res_run) begin
			rv_q <= 32'd0;
		end
	end

	mms_div #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.div_start(cmd.div_start),
		.num      (tgt_q),
		.den      (sum_rd_q),
		.div_busy (sts.div_busy),
		.factor   (factor)
	);

	assign sts.acc_zero   = (acc_q == '0);
	assign sts.step_below = (step_q < SUM_W'(tolerance));
	assign read_value     = rv_q;
endmodule

[rtl/mms_ctrl.sv]
// Controller: sequences host accesses and the column and row passes of a run.
// Depends on mms_pkg.
module mms_ctrl import mms_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int CIW      = 4,
	parameter int RIW      = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2:0]     mode,
	input  logic [4:0]     num_cols,
	input  logic [4:0]     num_rows,
	input  logic [15:0]    step_limit,
	input  sts_t           sts,
	output cmd_t           cmd,
	output logic [RIW-1:0] r_idx,
	output logic [CIW-1:0] c_idx,
	output logic           busy,
	output logic           done,
	output logic [1:0]     status,
	output logic [15:0]    steps_taken
);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int RW = $clog2(MAX_ROWS + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] c_cnt_q, nc;
	logic [RW-1:0] r_cnt_q, nr;
	logic          row_q;
	logic [15:0]   pass_q;
	stat_t         stat_q, stat_d;
	logic          stat_ld, pass_clr, pass_inc, ph_clr, ph_row;
	logic          in_clr, in_inc, out_clr, out_inc;
	logic          c_last, r_last, in_last, out_last, in_zero;

	// out-of-range sizes: zero acts as one, too large acts as the maximum
	always_comb begin
		if (num_cols == 5'd0) nc = CW'(1);
		else if (32'(num_cols) > 32'(MAX_COLS)) nc = CW'(MAX_COLS);
		else nc = CW'(num_cols);
		if (num_rows == 5'd0) nr = RW'(1);
		else if (32'(num_rows) > 32'(MAX_ROWS)) nr = RW'(MAX_ROWS);
		else nr = RW'(num_rows);
	end

	assign c_last   = (c_cnt_q == nc - 1'b1);
	assign r_last   = (r_cnt_q == nr - 1'b1);
	assign in_last  = row_q ? c_last : r_last;
	assign out_last = row_q ? r_last : c_last;
	assign in_zero  = row_q ? (c_cnt_q == '0) : (r_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_cnt_q <= '0;
			r_cnt_q <= '0;
			row_q   <= 1'b0;
			pass_q  <= '0;
			stat_q  <= STAT_CONV;
		end else begin
			if (ph_clr) row_q <= 1'b0;
			else if (ph_row) row_q <= 1'b1;
			if (pass_clr) pass_q <= '0;
			else if (pass_inc) pass_q <= pass_q + 16'd1;
			if (stat_ld) stat_q <= stat_d;
			// inner runs along rows in the column phase, along columns in the row phase
			if (in_clr) begin
				if (row_q) c_cnt_q <= '0;
				else r_cnt_q <= '0;
			end
			if (out_clr) begin
				if (row_q) r_cnt_q <= '0;
				else c_cnt_q <= '0;
			end
			if (in_inc) begin
				if (row_q) c_cnt_q <= c_cnt_q + 1'b1;
				else r_cnt_q <= r_cnt_q + 1'b1;
			end
			if (out_inc) begin
				if (row_q) r_cnt_q <= r_cnt_q + 1'b1;
				else c_cnt_q <= c_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		stat_d   = STAT_CONV;
		stat_ld  = 1'b0;
		pass_clr = 1'b0;
		pass_inc = 1'b0;
		ph_clr   = 1'b0;
		ph_row   = 1'b0;
		in_clr   = 1'b0;
		in_inc   = 1'b0;
		out_clr  = 1'b0;
		out_inc  = 1'b0;
		done     = 1'b0;
		cmd.row_phase = row_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_WR_ENTRY: cmd.host_wr_entry = 1'b1;
						MODE_WR_CTGT:  cmd.host_wr_ctgt = 1'b1;
						MODE_WR_RTGT:  cmd.host_wr_rtgt = 1'b1;
						MODE_RUN: begin
							pass_clr = 1'b1;
							state_d  = ST_PASS;
						end
						MODE_RD_ENTRY: begin
							cmd.host_rd = 1'b1;
							state_d     = ST_RD_WAIT;
						end
						default: ;
					endcase
				end
			end
			ST_RD_WAIT: begin
				cmd.res_read = 1'b1;
				stat_d       = STAT_READ;
				stat_ld      = 1'b1;
				state_d      = ST_REPLY;
			end
			ST_PASS: begin
				if (pass_q == step_limit) begin
					stat_d      = STAT_LIMIT;
					stat_ld     = 1'b1;
					cmd.res_run = 1'b1;
					state_d     = ST_REPLY;
				end else begin
					pass_inc     = 1'b1;
					cmd.step_clr = 1'b1;
					ph_clr       = 1'b1;
					in_clr       = 1'b1;
					out_clr      = 1'b1;
					state_d      = ST_SUM_RD;
				end
			end
			ST_SUM_RD: state_d = ST_SUM_ACC;
			ST_SUM_ACC: begin
				cmd.sum_acc   = 1'b1;
				cmd.acc_first = in_zero;
				if (in_last) begin
					state_d = ST_SUM_END;
				end else begin
					in_inc  = 1'b1;
					state_d = ST_SUM_RD;
				end
			end
			ST_SUM_END: begin
				if (sts.acc_zero) begin
					stat_d      = STAT_ZERO;
					stat_ld     = 1'b1;
					cmd.res_run = 1'b1;
					state_d     = ST_REPLY;
				end else begin
					cmd.sum_store = 1'b1;
					in_clr        = 1'b1;
					if (out_last) begin
						out_clr = 1'b1;
						state_d = ST_SCL_LD;
					end else begin
						out_inc = 1'b1;
						state_d = ST_SUM_RD;
					end
				end
			end
			ST_SCL_LD: state_d = ST_SCL_GAP;
			ST_SCL_GAP: begin
				cmd.gap_upd   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (!sts.div_busy) state_d = ST_SCL_RD;
			end
			ST_SCL_RD: state_d = ST_SCL_MUL;
			ST_SCL_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SCL_WR;
			end
			ST_SCL_WR: begin
				cmd.scl_wr = 1'b1;
				if (in_last) begin
					in_clr = 1'b1;
					if (out_last) begin
						out_clr = 1'b1;
						state_d = ST_PH_END;
					end else begin
						out_inc = 1'b1;
						state_d = ST_SCL_LD;
					end
				end else begin
					in_inc  = 1'b1;
					state_d = ST_SCL_RD;
				end
			end
			ST_PH_END: begin
				if (!row_q) begin
					ph_row  = 1'b1;
					state_d = ST_SUM_RD;
				end else if (sts.step_below) begin
					stat_d      = STAT_CONV;
					stat_ld     = 1'b1;
					cmd.res_run = 1'b1;
					state_d     = ST_REPLY;
				end else begin
					state_d = ST_PASS;
				end
			end
			ST_REPLY: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign r_idx       = r_cnt_q[RIW-1:0];
	assign c_idx       = c_cnt_q[CIW-1:0];
	assign busy        = (state_q != ST_IDLE);
	assign status      = stat_q;
	assign steps_taken = pass_q;
endmodule

[rtl/matrix_marginal_scaling.sv]
// Top level of the marginal scaling block: config registers, controller, datapath.
// Depends on mms_pkg, mms_ctrl, mms_dp.
//
// Usage: the host issues one command word per cycle on start/mode/row/col/value;
// a word is taken at a rising edge with start high and busy low. Entry and
// target writes give no result, and busy stays low. An entry read passes
// through ST_RD_WAIT and gives its result in ST_REPLY (done high for one
// cycle, status 3). A run walks the matrix one entry at a time out of a
// memory with one read and one write port: per pass, the column sums, then
// for each column a division and the scaling of its entries, and the same
// again for the rows. The divider yields one quotient bit per cycle.
// The run result (status 0, 1 or 2, steps_taken, read_value zero) is shown
// with done for exactly one cycle; the receiver cannot stall it.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// belong in idle time. Reset clears the control state and reloads the
// register defaults; the matrix and targets hold garbage until written.
module matrix_marginal_scaling import mms_pkg::*; #(
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [3:0]  row,
	input  logic [3:0]  col,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] steps_taken,
	output logic [31:0] read_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [4:0]     num_cols_q, num_rows_q;
	logic [31:0]    tolerance_q;
	logic [15:0]    step_limit_q;
	cmd_t           cmd;
	sts_t           sts;
	logic [RIW-1:0] r_idx;
	logic [CIW-1:0] c_idx;

	// config registers: hold until written; sizes and step limit drop upper bits of the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q   <= RST_NUM_COLS;
			num_rows_q   <= RST_NUM_ROWS;
			tolerance_q  <= RST_TOLERANCE;
			step_limit_q <= RST_STEP_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_COLS:   num_cols_q   <= cfg_data[4:0];
				REG_NUM_ROWS:   num_rows_q   <= cfg_data[4:0];
				REG_TOLERANCE:  tolerance_q  <= cfg_data;
				REG_STEP_LIMIT: step_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	mms_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .CIW(CIW), .RIW(RIW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.num_cols   (num_cols_q),
		.num_rows   (num_rows_q),
		.step_limit (step_limit_q),
		.sts        (sts),
		.cmd        (cmd),
		.r_idx      (r_idx),
		.c_idx      (c_idx),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.steps_taken(steps_taken)
	);

	mms_dp #(
		.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS),
		.CIW(CIW), .RIW(RIW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.r_idx     (r_idx),
		.c_idx     (c_idx),
		.row       (row),
		.col       (col),
		.value     (value),
		.tolerance (tolerance_q),
		.sts       (sts),
		.read_value(read_value)
	);
endmodule

[rtl/mms_chk.sv]
// Port-level checker for the marginal scaling block, bound to the top level.
// Depends on mms_pkg.
module mms_chk import mms_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] mode,
	input logic       done,
	input logic [1:0] status
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside a busy command");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_RD_ENTRY) |=> busy)
		else $error("read did not make the block busy");

	a_read_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_RD_ENTRY) |-> ##2 (done && status == STAT_READ))
		else $error("read reply missing or late");
endmodule

bind matrix_marginal_scaling mms_chk u_mms_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.mode  (mode),
	.done  (done),
	.status(status)
);

[verif/testbench.sv]
// Self-checking testbench for matrix_marginal_scaling: a directed table, then random words.
// Depends on mms_pkg and the RTL; a built-in scaling predictor or the table's expected reply checks every reply.
`timescale 1ns / 1ps

module testbench;
	import mms_pkg::*;

	localparam int WATCHDOG_LIMIT = 100000;
	localparam int ITEM_GOAL      = 1600;
	localparam int DRAIN_CYCLES   = 20;
	localparam logic [2:0] MODE_SPARE_5 = 3'd5;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam logic [31:0] Q_ONE = 32'h0100_0000;
	localparam logic [31:0] Q_TWO = 32'h0200_0000;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] steps;
		logic [31:0] rd_val;
	} reply_t;

	// one row of the directed table: either a register write or a command word
	typedef struct {
		bit          is_reg;
		reg_idx_t    idx;
		logic [31:0] data;
		logic [2:0]  md;
		logic [3:0]  r;
		logic [3:0]  c;
		logic [31:0] v;
		bit          typed;
		reply_t      want;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [3:0]  row;
	logic [3:0]  col;
	logic [31:0] value;
	logic        done;
	logic [1:0]  status;
	logic [15:0] steps_taken;
	logic [31:0] read_value;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	matrix_marginal_scaling dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .row(row), .col(col), .value(value),
		.done(done), .status(status), .steps_taken(steps_taken), .read_value(read_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// ---------------------------------------------------------------
	// Predictor state: the matrix, the targets, the last factors, the pass
	// counter and a shadow of the four registers.
	// ---------------------------------------------------------------
	logic [31:0] entry_mem [256];
	logic [31:0] col_goal [16];
	logic [31:0] row_goal [16];
	logic [31:0] col_gain [16];
	logic [31:0] row_gain [16];
	logic [15:0] pass_cnt;
	logic [4:0]  sh_cols;
	logic [4:0]  sh_rows;
	logic [31:0] sh_tol;
	logic [15:0] sh_limit;

	reply_t     pending_replies [$];
	table_row_t dir_tab [$];
	int         mismatches;
	int         items_sent;
	int         quiet_cycles;
	bit         no_idle_run;

	function automatic int clamp16(input logic [4:0] v);
		if (v == 0) return 1;
		if (v > 16) return 16;
		return int'(v);
	endfunction

	function automatic logic [31:0] gain_of(input logic [31:0] goal, input logic [63:0] sum);
		logic [63:0] q;
		q = ({32'd0, goal} << DEF_FRAC_BITS) / sum;
		return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic logic [31:0] scaled(input logic [31:0] e, input logic [31:0] f);
		logic [63:0] p;
		p = ({32'd0, e} * {32'd0, f}) >> DEF_FRAC_BITS;
		return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
	endfunction

	function automatic logic [63:0] abs_gap(input logic [63:0] s, input logic [31:0] g);
		return (s >= {32'd0, g}) ? s - {32'd0, g} : {32'd0, g} - s;
	endfunction

	// Run the whole scaling loop on the shadow matrix and return the status.
	function automatic logic [1:0] scale_matrix();
		int nc, nr, r, c;
		logic [63:0] sums [16];
		logic [63:0] worst, s;
		nc = clamp16(sh_cols);
		nr = clamp16(sh_rows);
		pass_cnt = 0;
		while (pass_cnt < sh_limit) begin
			worst = 0;
			pass_cnt++;
			for (c = 0; c < nc; c++) begin
				s = 0;
				for (r = 0; r < nr; r++) s += entry_mem[r*16+c];
				if (s == 0) return STAT_ZERO;
				sums[c] = s;
			end
			for (c = 0; c < nc; c++) begin
				if (abs_gap(sums[c], col_goal[c]) > worst) worst = abs_gap(sums[c], col_goal[c]);
				col_gain[c] = gain_of(col_goal[c], sums[c]);
			end
			for (c = 0; c < nc; c++)
				for (r = 0; r < nr; r++)
					entry_mem[r*16+c] = scaled(entry_mem[r*16+c], col_gain[c]);
			for (r = 0; r < nr; r++) begin
				s = 0;
				for (c = 0; c < nc; c++) s += entry_mem[r*16+c];
				if (s == 0) return STAT_ZERO;
				sums[r] = s;
			end
			for (r = 0; r < nr; r++) begin
				if (abs_gap(sums[r], row_goal[r]) > worst) worst = abs_gap(sums[r], row_goal[r]);
				row_gain[r] = gain_of(row_goal[r], sums[r]);
			end
			for (r = 0; r < nr; r++)
				for (c = 0; c < nc; c++)
					entry_mem[r*16+c] = scaled(entry_mem[r*16+c], row_gain[r]);
			if (worst < {32'd0, sh_tol}) return STAT_CONV;
		end
		return STAT_LIMIT;
	endfunction

	// Apply one accepted word to the shadow state; report whether it answers.
	function automatic bit predict_word(input logic [2:0] m, input logic [3:0] r,
			input logic [3:0] c, input logic [31:0] v, output reply_t rep);
		rep = '0;
		case (m)
			MODE_WR_ENTRY: entry_mem[r*16+c] = v;
			MODE_WR_CTGT:  col_goal[c] = v;
			MODE_WR_RTGT:  row_goal[r] = v;
			MODE_RUN: begin
				rep.status = scale_matrix();
				rep.steps  = pass_cnt;
				return 1;
			end
			MODE_RD_ENTRY: begin
				rep.status = STAT_READ;
				rep.steps  = pass_cnt;
				rep.rd_val = entry_mem[r*16+c];
				return 1;
			end
			default: ;
		endcase
		return 0;
	endfunction

	// ---------------------------------------------------------------
	// Driving side
	// ---------------------------------------------------------------

	// Send one command word after a random gap (none while no_idle_run is set) and hold it until taken.
	task automatic send_word(input logic [2:0] m, input logic [3:0] r, input logic [3:0] c,
			input logic [31:0] v, input bit typed, input reply_t want);
		int gap;
		reply_t rep;
		gap = no_idle_run ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode  <= m;
		row   <= r;
		col   <= c;
		value <= v;
		do @(posedge clk); while (busy);
		items_sent++;
		if (predict_word(m, r, c, v, rep))
			pending_replies.insert(pending_replies.size(), typed ? want : rep);
	endtask

	// Write a register once every reply is in and the block has settled.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		start <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_NUM_COLS:   sh_cols  = data[4:0];
			REG_NUM_ROWS:   sh_rows  = data[4:0];
			REG_TOLERANCE:  sh_tol   = data;
			REG_STEP_LIMIT: sh_limit = data[15:0];
			default: ;
		endcase
	endtask

	function automatic table_row_t reg_row(input reg_idx_t idx, input logic [31:0] data);
		table_row_t t;
		t.is_reg = 1;
		t.idx    = idx;
		t.data   = data;
		t.md     = '0;
		t.r      = '0;
		t.c      = '0;
		t.v      = '0;
		t.typed  = 0;
		t.want   = '0;
		return t;
	endfunction

	function automatic table_row_t word_row(input logic [2:0] m, input logic [3:0] r,
			input logic [3:0] c, input logic [31:0] v, input bit typed, input reply_t want);
		table_row_t t;
		t.is_reg = 0;
		t.idx    = REG_NUM_COLS;
		t.data   = '0;
		t.md = m; t.r = r; t.c = c; t.v = v;
		t.typed = typed;
		t.want  = want;
		return t;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input table_row_t t);
		dir_tab.insert(dir_tab.size(), t);
	endfunction

	// Entries and targets near 1.0 let runs settle; now and then hit zero or the top.
	function automatic logic [31:0] pick_value();
		int k;
		k = $urandom_range(0, 99);
		if (k < 4)  return 32'd0;
		if (k < 8)  return 32'hFFFF_FFFF;
		if (k < 30) return $urandom;
		return $urandom_range(32'h0040_0000, 32'h0300_0000);
	endfunction

	// Pick a fresh register setting; large sizes only with a short step limit.
	task automatic reconfigure();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) begin
			write_reg(REG_NUM_COLS, $urandom_range(16, 31));
			write_reg(REG_NUM_ROWS, $urandom_range(0, 1) ? 0 : $urandom_range(16, 31));
			write_reg(REG_STEP_LIMIT, $urandom_range(0, 2));
		end else if (k == 1) begin
			// tolerance at the top: the very first pass settles unless a sum gap is huge
			write_reg(REG_NUM_COLS, 1);
			write_reg(REG_NUM_ROWS, 1);
			write_reg(REG_STEP_LIMIT, 16'hFFFF);
			write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
			return;
		end else begin
			write_reg(REG_NUM_COLS, $urandom_range(1, 4));
			write_reg(REG_NUM_ROWS, $urandom_range(1, 4));
			write_reg(REG_STEP_LIMIT, $urandom_range(0, 8));
		end
		case ($urandom_range(0, 3))
			0: write_reg(REG_TOLERANCE, 32'd0);
			1: write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
			2: write_reg(REG_TOLERANCE, $urandom);
			default: write_reg(REG_TOLERANCE, $urandom_range(0, 32'h0010_0000));
		endcase
	endtask

	// ---------------------------------------------------------------
	// Reply checking: every done pulse is one reply, matched in order.
	// ---------------------------------------------------------------
	task automatic flag(input string what, input reply_t exp_r, input reply_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch %s: expected st=%0d steps=%0d val=%h, got st=%0d steps=%0d val=%h",
				$realtime, what, exp_r.status, exp_r.steps, exp_r.rd_val,
				got.status, got.steps, got.rd_val);
	endtask

	always @(posedge clk) begin
		reply_t got, exp_r;
		if (arst_n && done) begin
			got = '{status, steps_taken, read_value};
			if (pending_replies.size() == 0) begin
				flag("unexpected reply", '0, got);
			end else begin
				exp_r = pending_replies.pop_front();
				if (got.status !== exp_r.status) flag("status", exp_r, got);
				if (got.steps !== exp_r.steps) flag("steps_taken", exp_r, got);
				if (got.rd_val !== exp_r.rd_val) flag("read_value", exp_r, got);
			end
		end
	end

	// Watchdog: count cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		reply_t none;
		int k, r, c;
		logic [2:0] m;

		none = '0;
		mismatches = 0;
		items_sent = 0;
		quiet_cycles = 0;
		no_idle_run = 0;
		arst_n = 1'b0;
		start = 1'b0; mode = '0; row = '0; col = '0; value = '0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		sh_cols = RST_NUM_COLS; sh_rows = RST_NUM_ROWS;
		sh_tol = RST_TOLERANCE; sh_limit = RST_STEP_LIMIT;
		pass_cnt = 0;
		for (k = 0; k < 16; k++) begin
			col_gain[k] = 0;
			row_gain[k] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load every entry and target so nothing undefined is ever read or summed
		for (k = 0; k < 256; k++)
			send_word(MODE_WR_ENTRY, 4'(k / 16), 4'(k % 16), pick_value(), 0, none);
		for (k = 0; k < 16; k++) begin
			send_word(MODE_WR_CTGT, 4'd0, 4'(k), pick_value(), 0, none);
			send_word(MODE_WR_RTGT, 4'(k), 4'd0, pick_value(), 0, none);
		end

		// directed table: a 2x2 case with every sum on target, then the corners
		add_row(reg_row(REG_NUM_COLS, 2));
		add_row(reg_row(REG_NUM_ROWS, 2));
		add_row(reg_row(REG_TOLERANCE, 1));
		add_row(reg_row(REG_STEP_LIMIT, 5));
		for (k = 0; k < 4; k++)
			add_row(word_row(MODE_WR_ENTRY, 4'(k / 2), 4'(k % 2), Q_ONE, 0, none));
		for (k = 0; k < 2; k++) begin
			add_row(word_row(MODE_WR_CTGT, 4'd0, 4'(k), Q_TWO, 0, none));
			add_row(word_row(MODE_WR_RTGT, 4'(k), 4'd0, Q_TWO, 0, none));
		end
		add_row(word_row(MODE_RD_ENTRY, 0, 0, 0, 1, '{STAT_READ, 16'd0, Q_ONE}));
		// sums already on target: settles in one pass
		add_row(word_row(MODE_RUN, 0, 0, 0, 1, '{STAT_CONV, 16'd1, 32'd0}));
		add_row(word_row(MODE_RD_ENTRY, 1, 1, 0, 1, '{STAT_READ, 16'd1, Q_ONE}));
		// no passes allowed
		add_row(reg_row(REG_STEP_LIMIT, 0));
		add_row(word_row(MODE_RUN, 0, 0, 0, 1, '{STAT_LIMIT, 16'd0, 32'd0}));
		// an empty column stops the first pass
		add_row(reg_row(REG_STEP_LIMIT, 3));
		add_row(word_row(MODE_WR_ENTRY, 0, 0, 0, 0, none));
		add_row(word_row(MODE_WR_ENTRY, 1, 0, 0, 0, none));
		add_row(word_row(MODE_RUN, 0, 0, 0, 1, '{STAT_ZERO, 16'd1, 32'd0}));
		add_row(word_row(MODE_WR_ENTRY, 15, 15, 32'hFFFF_FFFF, 0, none));
		add_row(word_row(MODE_RD_ENTRY, 15, 15, 0, 1,
			'{STAT_READ, 16'd1, 32'hFFFF_FFFF}));
		// spare modes are dropped
		add_row(word_row(MODE_SPARE_5, 15, 15, 32'hFFFF_FFFF, 0, none));
		add_row(word_row(MODE_SPARE_6, 0, 0, 0, 0, none));
		add_row(word_row(MODE_SPARE_7, 3, 9, $urandom, 0, none));
		// zero target: column empties, next pass reports the zero sum
		add_row(word_row(MODE_WR_ENTRY, 0, 0, Q_ONE, 0, none));
		add_row(word_row(MODE_WR_ENTRY, 1, 0, Q_ONE, 0, none));
		add_row(word_row(MODE_WR_CTGT, 0, 0, 0, 0, none));
		add_row(word_row(MODE_RUN, 0, 0, 0, 0, none));
		// size registers out of range: zero acts as one, above sixteen as sixteen
		add_row(reg_row(REG_NUM_COLS, 0));
		add_row(reg_row(REG_NUM_ROWS, 31));
		add_row(reg_row(REG_STEP_LIMIT, 1));
		add_row(reg_row(REG_TOLERANCE, 32'hFFFF_FFFF));
		add_row(word_row(MODE_RUN, 0, 0, 0, 0, none));

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_reg)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				send_word(dir_tab[i].md, dir_tab[i].r, dir_tab[i].c, dir_tab[i].v,
					dir_tab[i].typed, dir_tab[i].want);
		end

		// random part: loads and reads, runs now and then, settings every hundred words
		while (items_sent < ITEM_GOAL) begin
			if (items_sent % 100 == 0) reconfigure();
			if ($urandom_range(0, 15) == 0) no_idle_run = !no_idle_run;
			k = $urandom_range(0, 99);
			r = (clamp16(sh_rows) < 16 && $urandom_range(0, 3) != 0) ?
				$urandom_range(0, clamp16(sh_rows) - 1) : $urandom_range(0, 15);
			c = (clamp16(sh_cols) < 16 && $urandom_range(0, 3) != 0) ?
				$urandom_range(0, clamp16(sh_cols) - 1) : $urandom_range(0, 15);
			if (k < 45)      m = MODE_WR_ENTRY;
			else if (k < 55) m = MODE_WR_CTGT;
			else if (k < 65) m = MODE_WR_RTGT;
			else if (k < 90) m = MODE_RD_ENTRY;
			else if (k < 96) m = MODE_RUN;
			else             m = 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
			send_word(m, 4'(r), 4'(c),
				(m == MODE_RUN || m == MODE_RD_ENTRY) ? $urandom : pick_value(), 0, none);
		end
		start <= 1'b0;

		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
